[rtl/utf8s_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_pkg: shared types and constants of the UTF-8 sanitiser
// Word types of both channels, the burst passed from classifier to
// serialiser, and the character constants used by the cleaning rules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_word_t;

    localparam int unsigned BURST_MAX  = 4;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [$clog2(BURST_MAX+1)-1:0]   burst_count_t;
    typedef logic [$clog2(BURST_MAX)-1:0]     burst_index_t;
    typedef logic [$clog2(QUEUE_DEPTH)-1:0]   queue_ptr_t;
    typedef logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_fill_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] octets;
        burst_count_t              count;
        logic                      last;
    } burst_t;

    typedef struct packed {
        logic   push;
        burst_t burst;
    } push_t;

    typedef struct packed {
        logic   valid;
        burst_t head;
    } head_t;

    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [2:0] SEQ_NONE  = 3'd0;
    localparam logic [2:0] SEQ_TWO   = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR  = 3'd4;

endpackage

[rtl/utf8_sanitizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer: UTF-8 validating byte cleaner
// Accepts one source byte per cycle while its four-entry burst queue has
// room; each byte yields zero to four cleaned bytes, which leave one per
// cycle while dst_stall is low, through the queue and output register.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle and, when the downstream side
// keeps up, delivers one cleaned byte per cycle. A source byte that closes
// or breaks a multi-byte sequence produces a burst of up to four bytes;
// these are serialised at one byte per cycle by the output stage, so the
// sustained input rate is one byte per cycle for ordinary text and falls to
// one byte per burst length where long bursts follow each other, with the
// four-entry burst queue absorbing short runs of them. Input stall is
// raised only while that queue is full.
module utf8_sanitizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  utf8s_pkg::in_word_t  src_data,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output utf8s_pkg::out_word_t dst_data
);

    utf8s_pkg::push_t push;
    utf8s_pkg::head_t head;
    logic             queue_full;
    logic             pop;
    logic             accept;

    assign src_stall = queue_full;
    assign accept    = src_valid && !queue_full;

    utf8s_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (src_data),
        .push   (push)
    );

    utf8s_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    utf8s_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .stall (dst_stall),
        .valid (dst_valid),
        .data  (dst_data)
    );

endmodule

[rtl/utf8s_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_front: byte classifier
// Tracks the open multi-byte sequence and turns each accepted byte into a
// burst of zero to four cleaned bytes for the queue.
// ----------------------------------------------------------------------------
module utf8s_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  utf8s_pkg::in_word_t word,
    output utf8s_pkg::push_t   push
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] seq_len_reg;
    logic [2:0] seq_len_next;

    logic       is_cont;
    logic       fresh;
    logic       emit_en;
    logic [7:0] emit_byte;
    logic [2:0] lead_len;
    utf8s_pkg::burst_t burst;

    assign is_cont = (word.in_byte[7:6] == 2'b10);

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        fresh           = 1'b1;
        emit_en         = 1'b0;
        emit_byte       = utf8s_pkg::CHAR_QMARK;
        lead_len        = utf8s_pkg::SEQ_NONE;
        for (int k = 0; k < utf8s_pkg::BURST_MAX; k++)
        begin
            burst.octets[k] = utf8s_pkg::CHAR_QMARK;
        end
        burst.count = '0;
        burst.last  = word.in_last;

        if (seq_len_reg != utf8s_pkg::SEQ_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (({1'b0, held_count_reg} + 3'd1) == seq_len_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        burst.octets[k] = held_reg[k];
                    end
                    burst.octets[held_count_reg] = word.in_byte;
                    burst.count     = {1'b0, held_count_reg} + 3'd1;
                    held_count_next = '0;
                    seq_len_next    = utf8s_pkg::SEQ_NONE;
                end
                else if (word.in_last || (held_count_reg == 2'd3))
                begin
                    burst.count     = {1'b0, held_count_reg} + 3'd1;
                    held_count_next = '0;
                    seq_len_next    = utf8s_pkg::SEQ_NONE;
                end
                else
                begin
                    held_next[held_count_reg] = word.in_byte;
                    held_count_next = held_count_reg + 2'd1;
                end
            end
            else
            begin
                burst.count     = {1'b0, held_count_reg};
                held_count_next = '0;
                seq_len_next    = utf8s_pkg::SEQ_NONE;
            end
        end

        if (fresh)
        begin
            case (word.in_byte) inside
                [8'h00:8'h7F]:
                begin
                    emit_en = 1'b1;
                    if ((word.in_byte >= utf8s_pkg::CHAR_SPACE) ||
                        (word.in_byte == utf8s_pkg::CHAR_TAB) ||
                        (word.in_byte == utf8s_pkg::CHAR_LF) ||
                        (word.in_byte == utf8s_pkg::CHAR_CR))
                    begin
                        emit_byte = word.in_byte;
                    end
                    else
                    begin
                        emit_byte = utf8s_pkg::CHAR_SPACE;
                    end
                end
                [8'hC0:8'hDF]: lead_len = utf8s_pkg::SEQ_TWO;
                [8'hE0:8'hEF]: lead_len = utf8s_pkg::SEQ_THREE;
                [8'hF0:8'hF7]: lead_len = utf8s_pkg::SEQ_FOUR;
                default:       emit_en  = 1'b1;
            endcase

            if (lead_len != utf8s_pkg::SEQ_NONE)
            begin
                if (word.in_last)
                begin
                    emit_en = 1'b1;
                end
                else
                begin
                    held_next[0]    = word.in_byte;
                    held_count_next = 2'd1;
                    seq_len_next    = lead_len;
                end
            end

            if (emit_en)
            begin
                burst.octets[burst.count[1:0]] = emit_byte;
                burst.count = burst.count + 3'd1;
            end
        end

        if (word.in_last)
        begin
            held_count_next = '0;
            seq_len_next    = utf8s_pkg::SEQ_NONE;
        end
    end

    assign push.push  = accept && (burst.count != '0);
    assign push.burst = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            seq_len_reg    <= utf8s_pkg::SEQ_NONE;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

[rtl/utf8s_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_queue: burst queue
// A small first-in first-out store of bursts between the classifier and
// the serialiser.
// ----------------------------------------------------------------------------
module utf8s_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  utf8s_pkg::push_t push,
    input  logic             pop,
    output logic             full,
    output utf8s_pkg::head_t head
);

    utf8s_pkg::burst_t      entry_reg [utf8s_pkg::QUEUE_DEPTH];
    utf8s_pkg::queue_ptr_t  wr_ptr_reg;
    utf8s_pkg::queue_ptr_t  wr_ptr_next;
    utf8s_pkg::queue_ptr_t  rd_ptr_reg;
    utf8s_pkg::queue_ptr_t  rd_ptr_next;
    utf8s_pkg::queue_fill_t fill_reg;
    utf8s_pkg::queue_fill_t fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (fill_reg == utf8s_pkg::queue_fill_t'(utf8s_pkg::QUEUE_DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.head  = entry_reg[rd_ptr_reg];

    assign do_push = push.push && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.burst;
        end
    end

endmodule

[rtl/utf8s_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_back: burst serialiser
// Walks the burst at the head of the queue and hands its bytes one at a
// time to the output register.
// ----------------------------------------------------------------------------
module utf8s_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8s_pkg::head_t     head,
    output logic                 pop,
    input  logic                 stall,
    output logic                 valid,
    output utf8s_pkg::out_word_t data
);

    utf8s_pkg::burst_index_t idx_reg;
    utf8s_pkg::burst_index_t idx_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    utf8s_pkg::out_word_t    out_data_reg;
    utf8s_pkg::out_word_t    out_data_next;
    logic                    load;
    logic                    at_end;

    assign load   = head.valid && (!out_valid_reg || !stall);
    assign at_end = ({1'b0, idx_reg} + 3'd1) == head.head.count;
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && stall;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = head.head.octets[idx_reg];
            out_data_next.out_last = head.head.last && at_end;
            idx_next               = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign valid = out_valid_reg;
    assign data  = out_data_reg;

endmodule

[rtl/utf8s_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_checker: port-level checks of the UTF-8 sanitiser
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module utf8s_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  logic                 src_stall,
    input  utf8s_pkg::in_word_t  src_data,
    input  logic                 dst_valid,
    input  logic                 dst_stall,
    input  utf8s_pkg::out_word_t dst_data
);

    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
        else $error("output word changed while stalled");

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid)
        else $error("input stalled with no output word on offer");

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(src_stall) |-> $past(src_valid && !src_stall))
        else $error("input stall raised without a preceding accepted word");

    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(src_data))
        else $error("input word changed while stalled");

endmodule

bind utf8_sanitizer utf8s_checker u_utf8s_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);
